FILE: rtl/jas_pkg.sv
// Shared types and constants of the joystick auto-calibrating scaler.
`default_nettype none
package jas_pkg;

	localparam int unsigned VAL_W  = 8;
	localparam int unsigned AXIS_W = 2;

	localparam logic [VAL_W-1:0] FULL_SCALE_RESET = 8'd200;
	localparam logic [VAL_W-1:0] ERASED_CODE      = 8'hFF;
	localparam logic [VAL_W-1:0] MID_CODE         = 8'd128;

	localparam logic ACT_SCALE   = 1'b0;
	localparam logic ACT_PRELOAD = 1'b1;

	typedef struct packed {
		logic              action;
		logic [AXIS_W-1:0] axis;
		logic [VAL_W-1:0]  sample;
		logic [VAL_W-1:0]  preset_min;
		logic [VAL_W-1:0]  preset_max;
	} jas_in_t;

	typedef struct packed {
		logic [AXIS_W-1:0] out_axis;
		logic [VAL_W-1:0]  position;
		logic              min_changed;
		logic              max_changed;
		logic [VAL_W-1:0]  new_min;
		logic [VAL_W-1:0]  new_max;
	} jas_out_t;

endpackage
`default_nettype wire

FILE: rtl/jas_div.sv
// Bit-serial restoring divider: 2W-bit dividend by W-bit divisor, W-bit quotient.
`default_nettype none
module jas_div
	import jas_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2*VAL_W-1:0] num,
	input  wire logic [VAL_W-1:0]   den,
	output logic                    done,
	output logic [VAL_W-1:0]        quot
);

	localparam int unsigned CNT_W = $clog2(VAL_W);

	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VAL_W:0] trial;
	logic [VAL_W:0] diff;
	logic           ge;

	// caller guarantees quotient fits W bits, so the top half is below den
	assign trial = {rem_q, quot_q[VAL_W-1]};
	assign ge    = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num[2*VAL_W-1:VAL_W];
				quot_q <= num[VAL_W-1:0];
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
				quot_q <= {quot_q[VAL_W-2:0], ge};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

FILE: rtl/joystick_autocal_scaler.sv
// Top level of the joystick auto-calibrating scaler.
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one action per transfer:
//   a sample to scale for an axis, or a preload of that axis's stored extremes.
//   Each scaled sample widens the axis's running min/max if needed and yields
//   one result on the output channel (out_valid/out_ready/out_data): position
//   (sample-min)*full_scale/(max-min), truncated, plus the updated extremes and
//   change flags. A flat range gives full_scale/2. Preloads and axes beyond the
//   configured count give no result.
//   Flow: a sample passes read, multiply, bit-serial divide and hand-over from
//   transfer to result register; a flat range skips the multiply and divide.
//   A preload or an out-of-range axis frees the input after the read.
//   in_ready is high only while the sequencer is idle, so one item is in
//   flight at a time; unless the receiver stalls, the divider's one bit per
//   cycle sets the rate.
//   A stalled receiver holds the result register; the next item is still taken
//   and its result waits until the register frees. The user writes full_scale
//   via cfg_we/cfg_wdata only while idle; the block does not enforce this.
//   Reset: extremes of every axis return to mid-scale, full_scale to 200,
//   no result pending.
`default_nettype none
module joystick_autocal_scaler
	import jas_pkg::*;
#(
	parameter int unsigned AXES = 3
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire jas_in_t    in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output jas_out_t        out_data,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	localparam int unsigned IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_START,
		ST_WAIT,
		ST_DONE
	} state_t;

	function automatic logic [VAL_W-1:0] restore(input logic [VAL_W-1:0] v);
		return (v == ERASED_CODE) ? MID_CODE : v;
	endfunction

	state_t               state_q;
	jas_in_t              in_q;
	logic [VAL_W-1:0]     min_q [AXES];
	logic [VAL_W-1:0]     max_q [AXES];
	logic [VAL_W-1:0]     full_scale_q;
	logic [VAL_W-1:0]     lo_q;
	logic [VAL_W-1:0]     hi_q;
	logic [VAL_W-1:0]     diff_q;
	logic [VAL_W-1:0]     span_q;
	logic                 min_ch_q;
	logic                 max_ch_q;
	logic [2*VAL_W-1:0]   prod_q;
	logic [VAL_W-1:0]     pos_q;
	logic                 out_valid_q;
	jas_out_t             out_q;

	logic [IDX_W-1:0]     idx;
	logic                 axis_ok;
	logic [VAL_W-1:0]     cur_lo;
	logic [VAL_W-1:0]     cur_hi;
	logic [VAL_W-1:0]     nxt_lo;
	logic [VAL_W-1:0]     nxt_hi;
	logic                 lower;
	logic                 higher;
	logic                 div_start;
	logic                 div_done;
	logic [VAL_W-1:0]     div_quot;
	logic                 out_free;
	logic                 out_load;

	assign idx     = IDX_W'(in_q.axis);
	assign axis_ok = 32'(in_q.axis) < AXES;
	assign cur_lo  = min_q[idx];
	assign cur_hi  = max_q[idx];
	assign lower   = in_q.sample < cur_lo;
	assign higher  = in_q.sample > cur_hi;
	assign nxt_lo  = lower ? in_q.sample : cur_lo;
	assign nxt_hi  = higher ? in_q.sample : cur_hi;

	assign in_ready  = state_q == ST_IDLE;
	assign div_start = state_q == ST_START;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == ST_DONE) && out_free;

	jas_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_q),
		.den   (span_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RESET;
		end else if (cfg_we) begin
			full_scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			in_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			diff_q      <= '0;
			span_q      <= '0;
			min_ch_q    <= 1'b0;
			max_ch_q    <= 1'b0;
			prod_q      <= '0;
			pos_q       <= '0;
			out_q       <= '0;
			for (int i = 0; i < AXES; i++) begin
				min_q[i] <= MID_CODE;
				max_q[i] <= MID_CODE;
			end
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						in_q    <= in_data;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (!axis_ok) begin
						state_q <= ST_IDLE;
					end else if (in_q.action == ACT_PRELOAD) begin
						min_q[idx] <= restore(in_q.preset_min);
						max_q[idx] <= restore(in_q.preset_max);
						state_q    <= ST_IDLE;
					end else begin
						min_q[idx] <= nxt_lo;
						max_q[idx] <= nxt_hi;
						lo_q       <= nxt_lo;
						hi_q       <= nxt_hi;
						min_ch_q   <= lower;
						max_ch_q   <= higher;
						diff_q     <= in_q.sample - nxt_lo;
						span_q     <= nxt_hi - nxt_lo;
						if (nxt_hi == nxt_lo) begin
							pos_q   <= full_scale_q >> 1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= (2*VAL_W)'(diff_q) * (2*VAL_W)'(full_scale_q);
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						pos_q   <= div_quot;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.out_axis    <= in_q.axis;
						out_q.position    <= pos_q;
						out_q.min_changed <= min_ch_q;
						out_q.max_changed <= max_ch_q;
						out_q.new_min     <= lo_q;
						out_q.new_max     <= hi_q;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
